// ===== rtl/aidr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aidr_pkg
// Shared types, codes and sizes for the ordered store with insert, delete,
// reverse and dump.
// ----------------------------------------------------------------------------
package aidr_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  // wide enough to compare a 6-bit position against any count
  localparam int CMP_W = 8;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_REVERSE = 2'd2;
  localparam logic [1:0] OP_DUMP    = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_REVERSE,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [5:0]         position;
    logic [CNT_W-1:0]   count;
    logic [31:0]        new_value;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         position;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [5:0]         slot;
    logic [6:0]         fill;
    logic               last;
  } rsp_t;

endpackage

// ===== rtl/aidr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aidr_cell
// One entry of the store. Picks its next value from its neighbors, the new
// value, the mirrored entry or the head, depending on the broadcast command.
// ----------------------------------------------------------------------------
module aidr_cell
  import aidr_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [31:0]       left,
  input  logic [31:0]       right,
  input  logic [31:0]       mirror,
  input  logic [31:0]       head,
  output logic [31:0]       data
);

  logic [31:0]      data_next;
  logic [CMP_W-1:0] idx_e;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] cnt_e;

  assign idx_e = CMP_W'(idx);
  assign pos_e = CMP_W'(ctl.position);
  assign cnt_e = CMP_W'(ctl.count);

  always_comb begin
    data_next = data;
    case (ctl.mode)
      CM_INSERT: begin
        if (idx_e > pos_e) begin
          data_next = left;
        end else if (idx_e == pos_e) begin
          data_next = ctl.new_value;
        end
      end
      CM_DELETE: begin
        if (idx_e >= pos_e) begin
          data_next = right;
        end
      end
      CM_REVERSE: begin
        if (idx_e < cnt_e) begin
          data_next = mirror;
        end
      end
      CM_ROTATE: begin
        // the occupied part turns left by one, head wraps to the tail
        if (idx_e + CMP_W'(1) == cnt_e) begin
          data_next = head;
        end else if (idx_e + CMP_W'(1) < cnt_e) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/array_insert_delete_reverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_reverse
// Ordered store of signed 32-bit entries kept in a row of cells, with
// insert, delete, reverse and dump operations.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req) carries one operation per
//   transfer; rsp channel (rsp_valid, rsp_stall, rsp) returns results.
//   Insert, delete and reverse give one result each, registered at the
//   transfer, and a new operation is taken every cycle while results drain.
//   Dump gives one result per cycle while rsp_stall is low, one per stored
//   entry with last set on the final one, the first registered from the dump
//   state after the transfer; req_stall stays high until the dump state ends.
//   An empty dump gives a single empty status result, registered at the
//   transfer.
//   Each dump step turns the row of cells left by one; after n steps the
//   order is back where it started.
//   Reset clears the fill count and the control; entry contents are not
//   cleared and only occupied entries are ever read.
//   When rsp_stall is high the pending result holds in the output register
//   and req_stall rises, so nothing is lost or skipped.
// ----------------------------------------------------------------------------
module array_insert_delete_reverse
  import aidr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] dump_idx;
  logic [IDX_W-1:0] dump_idx_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic             can_load;
  logic             req_take;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] cnt_e;
  logic             dump_last;
  cell_ctl_t        ctl;

  logic [31:0] cell_data  [DEPTH];
  logic [31:0] left_data  [DEPTH];
  logic [31:0] right_data [DEPTH];
  logic [31:0] mirror_data[DEPTH];

  assign can_load  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !can_load;
  assign req_take  = req_valid && !req_stall;
  assign pos_e     = CMP_W'(req.position);
  assign cnt_e     = CMP_W'(count);
  assign dump_last = (CNT_W'(dump_idx) + CNT_W'(1)) == count;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [CNT_W-1:0] mirror_idx;

      if (i == 0) begin : g_first
        assign left_data[i] = '0;
      end else begin : g_inner_l
        assign left_data[i] = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_final
        assign right_data[i] = '0;
      end else begin : g_inner_r
        assign right_data[i] = cell_data[i+1];
      end

      assign mirror_idx     = count - CNT_W'(1) - CNT_W'(i);
      assign mirror_data[i] = cell_data[mirror_idx[IDX_W-1:0]];

      aidr_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .idx    (IDX_W'(i)),
        .left   (left_data[i]),
        .right  (right_data[i]),
        .mirror (mirror_data[i]),
        .head   (cell_data[0]),
        .data   (cell_data[i])
      );
    end
  endgenerate

  always_comb begin
    state_next     = state;
    count_next     = count;
    dump_idx_next  = dump_idx;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;

    ctl.mode      = CM_HOLD;
    ctl.position  = req.position;
    ctl.count     = count;
    ctl.new_value = req.new_value;

    case (state)
      S_IDLE: begin
        if (req_take) begin
          rsp_valid_next  = 1'b1;
          rsp_next.status = STAT_OK;
          rsp_next.value  = '0;
          rsp_next.slot   = '0;
          rsp_next.last   = 1'b1;
          case (req.op)
            OP_INSERT: begin
              if (pos_e > cnt_e) begin
                rsp_next.status = STAT_BADPOS;
              end else if (count == CNT_W'(DEPTH)) begin
                rsp_next.status = STAT_FULL;
              end else begin
                ctl.mode   = CM_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (pos_e >= cnt_e) begin
                rsp_next.status = STAT_BADPOS;
              end else begin
                ctl.mode   = CM_DELETE;
                count_next = count - CNT_W'(1);
              end
            end
            OP_REVERSE: begin
              ctl.mode = CM_REVERSE;
            end
            OP_DUMP: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else begin
                // results come from the dump state
                rsp_valid_next = 1'b0;
                dump_idx_next  = '0;
                state_next     = S_DUMP;
              end
            end
            default: rsp_next.status = STAT_OK;
          endcase
          rsp_next.fill = 7'(count_next);
        end
      end
      S_DUMP: begin
        if (can_load) begin
          ctl.mode        = CM_ROTATE;
          rsp_valid_next  = 1'b1;
          rsp_next.status = STAT_OK;
          rsp_next.value  = cell_data[0];
          rsp_next.slot   = 6'(dump_idx);
          rsp_next.fill   = 7'(count);
          rsp_next.last   = dump_last;
          dump_idx_next   = dump_idx + IDX_W'(1);
          if (dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_idx  <= dump_idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

// ===== dv/array_insert_delete_reverse_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_reverse_tb
// Drives insert, delete, reverse and dump operations into the ordered store,
// keeps a shadow copy of the entries and the fill count, and checks every
// result against it: a short directed table first, then random traffic
// under several idle and stall mixes with a long output hold-off.
// ----------------------------------------------------------------------------
module array_insert_delete_reverse_tb;
  import aidr_pkg::*;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  typedef struct {
    bit   typed;
    rsp_t want;
  } typed_rsp_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // shadow of the store
  logic signed [31:0] shadow_entries [DEPTH];
  int                 shadow_count;

  rsp_t       pending_results [$];
  typed_rsp_t typed_rsp_q [$];
  dir_row_t   dir_rows [$];

  int err_count;
  int rsp_stall_pct;
  int hold_requests;
  bit grow;

  array_insert_delete_reverse DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // works out the results of one accepted operation and updates the shadow
  task automatic predict_store_op(input req_t item);
    rsp_t               r;
    logic signed [31:0] t;
    int                 i;
    r = '0;
    r.status = STAT_OK;
    r.last = 1'b1;
    case (item.op)
      OP_INSERT: begin
        if (int'(item.position) > shadow_count) begin
          r.status = STAT_BADPOS;
        end else if (shadow_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (i = shadow_count; i > int'(item.position); i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[int'(item.position)] = item.new_value;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (int'(item.position) >= shadow_count) begin
          r.status = STAT_BADPOS;
        end else begin
          for (i = int'(item.position); i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      OP_REVERSE: begin
        for (i = 0; i < shadow_count / 2; i++) begin
          t = shadow_entries[i];
          shadow_entries[i] = shadow_entries[shadow_count-1-i];
          shadow_entries[shadow_count-1-i] = t;
        end
      end
      default: ;
    endcase
    if (item.op == OP_DUMP && shadow_count > 0) begin
      for (i = 0; i < shadow_count; i++) begin
        r.status = STAT_OK;
        r.value = shadow_entries[i];
        r.slot = i[5:0];
        r.fill = shadow_count[6:0];
        r.last = (i + 1 == shadow_count);
        pending_results.push_back(r);
      end
    end else begin
      if (item.op == OP_DUMP)
        r.status = STAT_EMPTY;
      r.fill = shadow_count[6:0];
      pending_results.push_back(r);
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, value", got.value, 0);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.value !== want.value) report_mismatch("value", got.value, want.value);
      if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
      if (got.fill !== want.fill) report_mismatch("fill", got.fill, want.fill);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  // predict first so a same-edge result still finds its expectation
  always @(posedge clk) begin
    typed_rsp_t tr;
    if (!rst && req_valid && !req_stall) begin
      predict_store_op(req);
      tr = typed_rsp_q.pop_front();
      if (tr.typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(tr.want);
      end
    end
    if (!rst && rsp_valid && !rsp_stall)
      check_result(rsp);
  end

  // receiver: random stall, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served++;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
    end
  end

  function automatic dir_row_t row(input logic [1:0] op, input int pos,
                                   input logic [31:0] val, input bit typed,
                                   input logic [1:0] st, input int fill);
    dir_row_t d;
    d.item.op = op;
    d.item.position = pos[5:0];
    d.item.new_value = val;
    d.typed = typed;
    d.want = '0;
    d.want.status = st;
    d.want.fill = fill[6:0];
    d.want.last = 1'b1;
    return d;
  endfunction

  // mostly well-formed positions; drifts between filling and draining
  function automatic req_t next_random_item();
    req_t item;
    int   roll;
    if (shadow_count >= DEPTH) grow = 1'b0;
    if (shadow_count == 0) grow = 1'b1;
    roll = $urandom_range(99);
    if (roll < (grow ? 55 : 20))
      item.op = OP_INSERT;
    else if (roll < 75)
      item.op = OP_DELETE;
    else if (roll < 87)
      item.op = OP_REVERSE;
    else
      item.op = OP_DUMP;
    if ($urandom_range(99) < 15 || item.op == OP_REVERSE || item.op == OP_DUMP)
      item.position = 6'($urandom_range(63));
    else if (item.op == OP_INSERT)
      item.position = 6'($urandom_range(shadow_count));
    else
      item.position = (shadow_count > 0) ? 6'($urandom_range(shadow_count - 1)) : 6'd0;
    case ($urandom_range(7))
      0: item.new_value = 32'h8000_0000;
      1: item.new_value = 32'h7fff_ffff;
      2: item.new_value = '0;
      3: item.new_value = '1;
      default: item.new_value = $urandom;
    endcase
    return item;
  endfunction

  // called at a falling edge; returns at the edge where the transfer happens
  task automatic offer(input req_t item, input bit typed, input rsp_t want);
    typed_rsp_q.push_back('{typed: typed, want: want});
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic idle_gap(input int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  task automatic run_random(input int n, input int send_pct, input int rsp_pct);
    req_t item;
    rsp_stall_pct = rsp_pct;
    repeat (n) begin
      idle_gap(send_pct);
      @(negedge clk);
      item = next_random_item();
      offer(item, 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("array_insert_delete_reverse test failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    err_count = 0;
    rsp_stall_pct = 0;
    hold_requests = 0;
    grow = 1'b1;
    shadow_count = 0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;

    // empty store, bad positions, extreme values, every operation
    dir_rows.push_back(row(OP_DUMP,     0, 32'h0,         1, STAT_EMPTY,  0));
    dir_rows.push_back(row(OP_DELETE,   0, 32'h0,         1, STAT_BADPOS, 0));
    dir_rows.push_back(row(OP_DELETE,  63, 32'hffff_ffff, 1, STAT_BADPOS, 0));
    dir_rows.push_back(row(OP_INSERT,   1, 32'h1234_5678, 1, STAT_BADPOS, 0));
    dir_rows.push_back(row(OP_INSERT,  63, 32'h8000_0000, 1, STAT_BADPOS, 0));
    dir_rows.push_back(row(OP_REVERSE,  0, 32'h0,         1, STAT_OK,     0));
    dir_rows.push_back(row(OP_INSERT,   0, 32'h7fff_ffff, 1, STAT_OK,     1));
    dir_rows.push_back(row(OP_REVERSE, 63, 32'h0,         1, STAT_OK,     1));
    dir_rows.push_back(row(OP_DUMP,     0, 32'h0,         0, STAT_OK,     0));
    dir_rows.push_back(row(OP_INSERT,   1, 32'h8000_0000, 1, STAT_OK,     2));
    dir_rows.push_back(row(OP_INSERT,   0, 32'h0000_0000, 1, STAT_OK,     3));
    dir_rows.push_back(row(OP_INSERT,   3, 32'hffff_ffff, 1, STAT_OK,     4));
    dir_rows.push_back(row(OP_INSERT,   2, 32'h5a5a_5a5a, 1, STAT_OK,     5));
    dir_rows.push_back(row(OP_DUMP,    21, 32'h0,         0, STAT_OK,     0));
    dir_rows.push_back(row(OP_REVERSE,  0, 32'h0,         1, STAT_OK,     5));
    dir_rows.push_back(row(OP_DUMP,     0, 32'ha5a5_a5a5, 0, STAT_OK,     0));
    dir_rows.push_back(row(OP_DELETE,   4, 32'h0,         1, STAT_OK,     4));
    dir_rows.push_back(row(OP_DELETE,   0, 32'h0,         1, STAT_OK,     3));
    dir_rows.push_back(row(OP_DELETE,   3, 32'h0,         1, STAT_BADPOS, 3));
    dir_rows.push_back(row(OP_INSERT,  42, 32'h0,         1, STAT_BADPOS, 3));
    dir_rows.push_back(row(OP_DELETE,   1, 32'h0,         1, STAT_OK,     2));
    dir_rows.push_back(row(OP_DUMP,     0, 32'h0,         0, STAT_OK,     0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      @(negedge clk);
      offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();

    run_random(70, 0, 0);
    drain_results();
    run_random(60, 79, 0);
    run_random(60, 0, 79);
    run_random(60, 11, 11);
    drain_results();
    // long output hold-off while transfers keep coming
    hold_requests++;
    run_random(50, 0, 0);

    @(negedge clk);
    req_valid <= 1'b0;
    rsp_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results never seen, count", pending_results.size(), 0);
    if (err_count == 0) begin
      $display("array_insert_delete_reverse test passed");
    end else begin
      $display("array_insert_delete_reverse test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aidr_pkg.sv
rtl/aidr_cell.sv
rtl/array_insert_delete_reverse.sv
dv/array_insert_delete_reverse_tb.sv
